/* rtl/fnn_pkg.sv */
// Package for the 8.3 file name normalizer.
// Holds the field widths, the collector snapshot type and the ASCII class functions.
// Depends on nothing; every other file of the block uses it.
package fnn_pkg;

    localparam int unsigned NAME_LEN = 8;
    localparam int unsigned EXT_LEN  = 3;
    localparam int unsigned NAME_MAX = 8;
    localparam int unsigned EXT_MAX  = 3;

    localparam int unsigned NAME_CNT_W = $clog2(NAME_MAX + 1);
    localparam int unsigned EXT_CNT_W  = $clog2(EXT_MAX + 1);
    localparam int unsigned NAME_IDX_W = $clog2(NAME_MAX);
    localparam int unsigned EXT_IDX_W  = $clog2(EXT_MAX);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    typedef enum logic [2:0] {
        PH_NAME = 3'b001,
        PH_EXT  = 3'b010,
        PH_DONE = 3'b100
    } t_phase;

    typedef struct packed {
        logic [NAME_MAX-1:0][7:0] name;
        logic [EXT_MAX-1:0][7:0]  ext;
        logic                     bad_end;
    } t_snap;

    function automatic logic is_cntrl(input logic [7:0] c);
        return (c < 8'h20) || (c == CH_DEL);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
    endfunction

endpackage

/* rtl/fnn_if.sv */
// Valid/ready channel interfaces for the 8.3 file name normalizer.
// Depends on fnn_pkg for the result field widths.
interface fnn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink (input valid, input ch, input last, output ready);
endinterface

interface fnn_out_if;
    logic                           valid;
    logic                           ready;
    logic [fnn_pkg::NAME_MAX*8-1:0] name_text;
    logic [fnn_pkg::EXT_MAX*8-1:0]  ext_text;
    logic                           name_valid;

    modport source (output valid, output name_text, output ext_text, output name_valid,
                    input ready);
    modport sink (input valid, input name_text, input ext_text, input name_valid,
                  output ready);
endinterface

/* rtl/fnn_collect.sv */
// Input register and name/extension collector of the 8.3 file name normalizer.
// Depends on fnn_pkg and on fnn_in_if.
module fnn_collect (
    input  logic           i_clk,
    input  logic           i_rst_n,
    fnn_in_if.sink         i_in,
    input  logic           i_out_free,
    output fnn_pkg::t_snap o_snap,
    output logic           o_emit
);

    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_last;

    logic [fnn_pkg::NAME_MAX-1:0][7:0]  r_name, n_name, w_name;
    logic [fnn_pkg::EXT_MAX-1:0][7:0]   r_ext, n_ext, w_ext;
    logic [fnn_pkg::NAME_CNT_W-1:0]     r_name_cnt, n_name_cnt, w_name_cnt;
    logic [fnn_pkg::EXT_CNT_W-1:0]      r_ext_cnt, n_ext_cnt, w_ext_cnt;
    fnn_pkg::t_phase                    r_phase, n_phase, w_phase;
    logic                               r_bad_end, n_bad_end, w_bad_end;

    logic in_end;
    logic adv;
    logic take;

    assign in_end = (r_ch == fnn_pkg::CH_NUL) || r_last;
    // A beat that ends a string waits in the input register until the result register frees.
    assign adv    = r_in_valid && (!in_end || i_out_free);
    assign take   = !r_in_valid || adv;
    assign i_in.ready = take;

    always_comb begin
        w_name     = r_name;
        w_ext      = r_ext;
        w_name_cnt = r_name_cnt;
        w_ext_cnt  = r_ext_cnt;
        w_phase    = r_phase;
        w_bad_end  = r_bad_end;
        case (r_phase)
            fnn_pkg::PH_NAME: begin
                if ((r_name_cnt < fnn_pkg::NAME_CNT_W'(fnn_pkg::NAME_LEN)) &&
                    !fnn_pkg::is_cntrl(r_ch) && (r_ch != fnn_pkg::CH_DOT)) begin
                    w_name[r_name_cnt[fnn_pkg::NAME_IDX_W-1:0]] = r_ch;
                    w_name_cnt = r_name_cnt + 1'b1;
                end else if (r_ch == fnn_pkg::CH_DOT) begin
                    w_phase = fnn_pkg::PH_EXT;
                end else begin
                    w_bad_end = (r_ch != fnn_pkg::CH_SPACE) && (r_ch != fnn_pkg::CH_NUL);
                    w_phase   = fnn_pkg::PH_DONE;
                end
            end
            fnn_pkg::PH_EXT: begin
                if ((r_ch != fnn_pkg::CH_NUL) &&
                    (r_ext_cnt < fnn_pkg::EXT_CNT_W'(fnn_pkg::EXT_LEN))) begin
                    w_ext[r_ext_cnt[fnn_pkg::EXT_IDX_W-1:0]] = r_ch;
                    w_ext_cnt = r_ext_cnt + 1'b1;
                    if (w_ext_cnt >= fnn_pkg::EXT_CNT_W'(fnn_pkg::EXT_LEN)) begin
                        w_phase = fnn_pkg::PH_DONE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_name     = r_name;
        n_ext      = r_ext;
        n_name_cnt = r_name_cnt;
        n_ext_cnt  = r_ext_cnt;
        n_phase    = r_phase;
        n_bad_end  = r_bad_end;
        if (adv) begin
            if (in_end) begin
                n_name     = {fnn_pkg::NAME_MAX{fnn_pkg::CH_SPACE}};
                n_ext      = {fnn_pkg::EXT_MAX{fnn_pkg::CH_SPACE}};
                n_name_cnt = '0;
                n_ext_cnt  = '0;
                n_phase    = fnn_pkg::PH_NAME;
                n_bad_end  = 1'b0;
            end else begin
                n_name     = w_name;
                n_ext      = w_ext;
                n_name_cnt = w_name_cnt;
                n_ext_cnt  = w_ext_cnt;
                n_phase    = w_phase;
                n_bad_end  = w_bad_end;
            end
        end
    end

    assign o_snap.name    = w_name;
    assign o_snap.ext     = w_ext;
    assign o_snap.bad_end = w_bad_end;
    assign o_emit         = adv && in_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_name     <= {fnn_pkg::NAME_MAX{fnn_pkg::CH_SPACE}};
            r_ext      <= {fnn_pkg::EXT_MAX{fnn_pkg::CH_SPACE}};
            r_name_cnt <= '0;
            r_ext_cnt  <= '0;
            r_phase    <= fnn_pkg::PH_NAME;
            r_bad_end  <= 1'b0;
        end else begin
            if (take) begin
                r_in_valid <= i_in.valid;
            end
            r_name     <= n_name;
            r_ext      <= n_ext;
            r_name_cnt <= n_name_cnt;
            r_ext_cnt  <= n_ext_cnt;
            r_phase    <= n_phase;
            r_bad_end  <= n_bad_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_in.valid) begin
            r_ch   <= i_in.ch;
            r_last <= i_in.last;
        end
    end

endmodule

/* rtl/fnn_format.sv */
// Result formatter of the 8.3 file name normalizer: uppercases the name and
// extension, blanks trailing extension bytes, judges legality. Depends on fnn_pkg.
module fnn_format (
    input  fnn_pkg::t_snap                 i_snap,
    output logic [fnn_pkg::NAME_MAX*8-1:0] o_name_text,
    output logic [fnn_pkg::EXT_MAX*8-1:0]  o_ext_text,
    output logic                           o_name_valid
);

    logic [fnn_pkg::EXT_MAX-1:0] sig;
    logic [fnn_pkg::EXT_MAX-1:0] keep;

    always_comb begin
        for (int k = 0; k < fnn_pkg::NAME_MAX; k++) begin
            o_name_text[(fnn_pkg::NAME_MAX-1-k)*8 +: 8] = fnn_pkg::to_upper(i_snap.name[k]);
        end
        for (int k = 0; k < fnn_pkg::EXT_MAX; k++) begin
            sig[k] = !fnn_pkg::is_space(i_snap.ext[k]) && !fnn_pkg::is_cntrl(i_snap.ext[k]);
        end
        // Kept when it or any later position holds a non-space, non-control byte.
        keep[fnn_pkg::EXT_MAX-1] = sig[fnn_pkg::EXT_MAX-1];
        for (int k = fnn_pkg::EXT_MAX-2; k >= 0; k--) begin
            keep[k] = sig[k] || keep[k+1];
        end
        for (int k = 0; k < fnn_pkg::EXT_MAX; k++) begin
            o_ext_text[(fnn_pkg::EXT_MAX-1-k)*8 +: 8] =
                keep[k] ? fnn_pkg::to_upper(i_snap.ext[k]) : fnn_pkg::CH_SPACE;
        end
        o_name_valid = !i_snap.bad_end && fnn_pkg::is_alnum(fnn_pkg::to_upper(i_snap.name[0]));
    end

endmodule

/* rtl/filename_8_3_normalizer.sv */
// Top level of the 8.3 file name normalizer: collector, formatter and result register.
// Depends on fnn_pkg, fnn_if, fnn_collect and fnn_format.
//
// Usage:
//   i_in carries one file name byte per beat (ch) with a last flag. A string ends on
//   a zero byte or on a beat with last set; that beat is processed first.
//   o_out carries one result beat per string: name_text (8 bytes, first byte in the
//   top bits), ext_text (3 bytes) and name_valid.
// Timing:
//   A beat goes into the input register; from there it is classified and stored, and a
//   string-ending beat loads the result register in that same cycle once the result
//   register is free. The result is shown from the result register. One beat is taken
//   every cycle while no string-ending beat waits in the input register.
// Stalls:
//   While a result waits, ordinary bytes keep flowing. A second string-ending beat
//   waits in the input register, with i_in.ready low, until the result is taken.
// Reset:
//   Synchronous and active low. Stores return to spaces, counts to zero, collection
//   restarts at the name, and both registers come up empty.
module filename_8_3_normalizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fnn_in_if.sink     i_in,
    fnn_out_if.source  o_out
);

    fnn_pkg::t_snap snap;
    logic           emit;
    logic           out_free;

    logic [fnn_pkg::NAME_MAX*8-1:0] name_text;
    logic [fnn_pkg::EXT_MAX*8-1:0]  ext_text;
    logic                           name_valid;

    logic                           r_out_valid;
    logic [fnn_pkg::NAME_MAX*8-1:0] r_name_text;
    logic [fnn_pkg::EXT_MAX*8-1:0]  r_ext_text;
    logic                           r_name_valid;

    assign out_free = !r_out_valid || o_out.ready;

    fnn_collect u_collect (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_out_free (out_free),
        .o_snap     (snap),
        .o_emit     (emit)
    );

    fnn_format u_format (
        .i_snap       (snap),
        .o_name_text  (name_text),
        .o_ext_text   (ext_text),
        .o_name_valid (name_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_name_text  <= name_text;
            r_ext_text   <= ext_text;
            r_name_valid <= name_valid;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.name_text  = r_name_text;
    assign o_out.ext_text   = r_ext_text;
    assign o_out.name_valid = r_name_valid;

endmodule
